[rtl/tma_pkg.sv]
// Package with shared constants, types and command/status structs for the trimmed average core.
`default_nettype none

package tma_pkg;

  // Window and sample geometry.
  localparam int WINDOW_LEN = 7;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(WINDOW_LEN);
  localparam int SUM_W      = DATA_W + $clog2(WINDOW_LEN);

  // Constant divisor and the digit-serial divider geometry.
  localparam int DIVISOR    = WINDOW_LEN - 2;
  localparam int REM_W      = $clog2(DIVISOR + 1);
  localparam int DIV_STEP   = 7;
  localparam int DIV_CYCLES = (SUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
  localparam int DCNT_W     = $clog2(DIV_CYCLES);

  localparam logic [REM_W:0]    DIVISOR_V  = (REM_W + 1)'(DIVISOR);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(WINDOW_LEN - 1);
  localparam logic [DCNT_W-1:0] LAST_DSTEP = DCNT_W'(DIV_CYCLES - 1);

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_TRIM = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } tma_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic walk_en;
    logic trim_en;
    logic div_en;
    logic load_out;
  } tma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_last;
    logic div_last;
  } tma_sts_t;

endpackage

`default_nettype wire

[rtl/tma_ctrl.sv]
// Controller state machine that sequences the window walk, the trim and the divide.
`default_nettype none

module tma_ctrl
  import tma_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire tma_sts_t sts,
  output tma_cmd_t      cmd
);

  tma_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // A result slot is free when it is empty or its transfer happens now.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Commands are decoded from the current state; accept also needs in_valid and load_out a free result slot.
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.walk_en  = (state_r == S_WALK);
    cmd.trim_en  = (state_r == S_TRIM);
    cmd.div_en   = (state_r == S_DIV);
    cmd.load_out = (state_r == S_OUT) && out_free;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_last) state_nxt = S_TRIM;
      end
      S_TRIM: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output valid flag is set on a load and cleared by a transfer.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted sample always starts a window walk.
  a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_WALK))
    else $error("accepted sample did not start a walk");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending result");

  // The state register stays one-hot.
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register is not one-hot");
`endif

endmodule

`default_nettype wire

[rtl/tma_dpath.sv]
// Datapath with the sample window, the walk accumulator and the digit-serial divider.
`default_nettype none

module tma_dpath
  import tma_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tma_cmd_t          cmd,
  output tma_sts_t               sts,
  input  wire logic [DATA_W-1:0] in_sample_ns,
  output logic [DATA_W-1:0]      out_trimmed_mean
);

  logic [DATA_W-1:0] window_r [WINDOW_LEN];
  logic [IDX_W-1:0]  slot_r;
  logic [IDX_W-1:0]  walk_idx_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DATA_W-1:0] min_r;
  logic [DATA_W-1:0] max_r;
  logic [DATA_W-1:0] cur_val;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0] dcnt_r;
  logic [DATA_W-1:0] mean_r;
  logic [SUM_W-1:0]  trim_sum;

  // Status back to the controller.
  assign sts.walk_last = (walk_idx_r == LAST_IDX);
  assign sts.div_last  = (dcnt_r == LAST_DSTEP);

  // Entry visited by the walk and the trimmed sum.
  assign cur_val  = window_r[walk_idx_r];
  assign trim_sum = sum_r - SUM_W'(min_r) - SUM_W'(max_r);

  // Sample window and write slot; the window resets to all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_r[i] <= '0;
      end
      slot_r <= '0;
    end else if (cmd.accept) begin
      window_r[slot_r] <= in_sample_ns;
      slot_r           <= (slot_r == LAST_IDX) ? '0 : slot_r + 1'b1;
    end
  end

  // Walk over the window: running sum, minimum and maximum.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      walk_idx_r <= '0;
      sum_r      <= '0;
      min_r      <= '1;
      max_r      <= '0;
    end else if (cmd.walk_en) begin
      walk_idx_r <= walk_idx_r + 1'b1;
      sum_r      <= sum_r + SUM_W'(cur_val);
      if (cur_val < min_r) min_r <= cur_val;
      if (cur_val > max_r) max_r <= cur_val;
    end
  end

  // One long-division step per bit, several bits per cycle on a narrow remainder.
  always_comb begin
    logic [REM_W:0]    r;
    logic [DIV_STEP-1:0] q;
    r = '0;
    q = '0;
    rem_nxt = rem_r;
    for (int k = 0; k < DIV_STEP; k++) begin
      r = {rem_nxt, dvd_r[DIV_W-1-k]};
      if (r >= DIVISOR_V) begin
        r = r - DIVISOR_V;
        q[DIV_STEP-1-k] = 1'b1;
      end
      rem_nxt = r[REM_W-1:0];
    end
    dvd_nxt = {dvd_r[DIV_W-DIV_STEP-1:0], q};
  end

  // Divider registers: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (cmd.trim_en) begin
      rem_r <= '0;
    end else if (cmd.div_en) begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trim_en) begin
      dvd_r  <= DIV_W'(trim_sum);
      dcnt_r <= '0;
    end else if (cmd.div_en) begin
      dvd_r  <= dvd_nxt;
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // Output register; the quotient always fits in the sample width.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_r <= dvd_r[DATA_W-1:0];
    end
  end

  assign out_trimmed_mean = mean_r;

`ifndef NO_ASSERTIONS
  // After a full walk the minimum cannot exceed the maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.trim_en |-> (min_r <= max_r))
    else $error("minimum above maximum after walk");

  // The division remainder stays below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rem_r} < DIVISOR_V))
    else $error("division remainder out of range");
`endif

endmodule

`default_nettype wire

[rtl/trimmed_moving_average_core.sv]
// Each sample is written to the window; the core then walks the window, trims the min and max,
// divides by WINDOW_LEN - 2 and loads the result, with a one-entry-per-cycle window walk
// and a 7-bit-per-cycle divide. No new sample is taken until the result is loaded (in_stall).
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active low) zeroes the window and write slot at once, no clearing pass.
`default_nettype none

module trimmed_moving_average_core
  import tma_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DATA_W-1:0] in_sample_ns,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DATA_W-1:0]      out_trimmed_mean
);

  tma_cmd_t cmd;
  tma_sts_t sts;

  // Sequencer for one sample at a time.
  tma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Window storage, accumulation and divide.
  tma_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample_ns     (in_sample_ns),
    .out_trimmed_mean (out_trimmed_mean)
  );

endmodule

`default_nettype wire
